### hdl/largest_free_square_dp_unit_macros.svh
// ----------------------------------------------------------------------------
// largest free square dp unit: assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef LARGEST_FREE_SQUARE_DP_UNIT_MACROS_SVH
`define LARGEST_FREE_SQUARE_DP_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define LFSQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define LFSQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/lfsq_pkg.sv
// ----------------------------------------------------------------------------
// lfsq_pkg
// types and constants of the largest free square dp unit
// ----------------------------------------------------------------------------
package lfsq_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int SIDE_W     = 11;
  localparam int POS_W      = 10;

  typedef struct packed {
    logic cell_free;
    logic last_cell;
  } lfsq_item_t;

  typedef struct packed {
    logic [SIDE_W-1:0] square_side;
    logic [SIDE_W-1:0] best_side;
    logic [POS_W-1:0]  best_row;
    logic [POS_W-1:0]  best_column;
    logic              grid_done;
  } lfsq_result_t;

endpackage

### hdl/largest_free_square_dp_unit.sv
// output: a result is registered in the output register, or parked in the skid stage while the output stalls
// throughput: one cell per cycle while the skid stage is empty, set by the single line buffer port pair
//   (one read, one write per cycle) and the min-of-three update
// reset: synchronous, clears counters, running best and handshake state;
//   width register resets to 1; line buffer contents are not cleared
// ----------------------------------------------------------------------------
// largest_free_square_dp_unit
// streamed maximal free square over a binary grid with a one-row line buffer
// ----------------------------------------------------------------------------
module largest_free_square_dp_unit (
  input  logic                        clk,
  input  logic                        rst,
  // width register write
  input  logic                        cfg_wen,
  input  logic [lfsq_pkg::SIDE_W-1:0] cfg_wdata,
  // cell stream
  input  logic                        item_valid,
  output logic                        item_ready,
  input  lfsq_pkg::lfsq_item_t        item,
  // result stream
  output logic                        result_valid,
  input  logic                        result_ready,
  output lfsq_pkg::lfsq_result_t      result
);
  import lfsq_pkg::*;

  localparam logic [SIDE_W-1:0] WIDTH_MAX = SIDE_W'(MAX_WIDTH);
  localparam logic [SIDE_W-1:0] SIDE_SAT  = {SIDE_W{1'b1}};
  localparam logic [POS_W-1:0]  ROW_LAST  = POS_W'(MAX_HEIGHT - 1);

  // configuration
  logic [SIDE_W-1:0] grid_width;

  // line buffer: previous row sides, one entry per column
  logic [SIDE_W-1:0] row_mem [MAX_WIDTH];
  logic [SIDE_W-1:0] rdata;
  logic              fwd;
  logic [SIDE_W-1:0] fwd_data;

  // running grid state
  logic [SIDE_W-1:0] left_side;
  logic [SIDE_W-1:0] diagonal_side;
  logic [POS_W-1:0]  column_count;
  logic [POS_W-1:0]  column_count_next;
  logic [POS_W-1:0]  row_count;
  logic [POS_W-1:0]  row_count_next;
  logic [SIDE_W-1:0] best_size;
  logic [POS_W-1:0]  best_row;
  logic [POS_W-1:0]  best_column;

  // output register plus skid stage
  lfsq_result_t      skid;
  logic              skid_valid;

  logic              item_fire;
  logic              result_fire;
  logic [SIDE_W-1:0] width_eff;
  logic [SIDE_W-1:0] col_inc;
  logic [SIDE_W-1:0] above;
  logic [SIDE_W-1:0] min_al;
  logic [SIDE_W-1:0] min_all;
  logic [SIDE_W-1:0] side;
  logic              better;
  lfsq_result_t      res;

  // input held off in reset and while the skid stage is full
  assign item_ready  = !rst && !skid_valid;
  assign item_fire   = item_valid && item_ready;
  assign result_fire = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= SIDE_W'(1);
    end else if (cfg_wen) begin
      grid_width <= cfg_wdata;
    end
  end

  // clamp width into 1..max
  always_comb begin
    if (grid_width == '0) begin
      width_eff = SIDE_W'(1);
    end else if (grid_width > WIDTH_MAX) begin
      width_eff = WIDTH_MAX;
    end else begin
      width_eff = grid_width;
    end
  end

  // above value: registered read, or the side written the same cycle it was read
  // (happens when the next cell reads the column just written, e.g. width one)
  assign above = fwd ? fwd_data : rdata;

  // free cells take min(above, left, above-left) + 1, saturating; blocked cells 0; row/col 0 the free bit
  always_comb begin
    min_al  = (above < left_side) ? above : left_side;
    min_all = (min_al < diagonal_side) ? min_al : diagonal_side;
    if (row_count == '0 || column_count == '0) begin
      side = {{(SIDE_W-1){1'b0}}, item.cell_free};
    end else if (item.cell_free) begin
      side = (min_all == SIDE_SAT) ? SIDE_SAT : min_all + SIDE_W'(1);
    end else begin
      side = '0;
    end
    better = side > best_size;
  end

  always_comb begin
    res.square_side = side;
    res.best_side   = better ? side         : best_size;
    res.best_row    = better ? row_count    : best_row;
    res.best_column = better ? column_count : best_column;
    res.grid_done   = item.last_cell;
  end

  // position after this transfer
  assign col_inc = {1'b0, column_count} + SIDE_W'(1);

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (item_fire) begin
      if (item.last_cell) begin
        column_count_next = '0;
        row_count_next    = '0;
      end else if (col_inc >= width_eff) begin
        column_count_next = '0;
        if (row_count < ROW_LAST) begin
          row_count_next = row_count + POS_W'(1);
        end
      end else begin
        column_count_next = col_inc[POS_W-1:0];
      end
    end
  end

  // line buffer: write the new side, prefetch the column of the next cell
  always_ff @(posedge clk) begin
    if (item_fire) begin
      row_mem[column_count] <= side;
    end
    rdata <= row_mem[column_count_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else begin
      fwd <= item_fire && (column_count == column_count_next);
    end
    fwd_data <= side;
  end

  // grid state update
  always_ff @(posedge clk) begin
    if (rst) begin
      left_side     <= '0;
      diagonal_side <= '0;
      column_count  <= '0;
      row_count     <= '0;
      best_size     <= '0;
      best_row      <= '0;
      best_column   <= '0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      if (item_fire) begin
        if (item.last_cell) begin
          left_side     <= '0;
          diagonal_side <= '0;
          best_size     <= '0;
          best_row      <= '0;
          best_column   <= '0;
        end else begin
          left_side     <= side;
          diagonal_side <= above;
          if (better) begin
            best_size   <= side;
            best_row    <= row_count;
            best_column <= column_count;
          end
        end
      end
    end
  end

  // output register with skid: a stalled result parks the next one in skid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || result_fire) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= item_fire;
      end
    end else if (item_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || result_fire) begin
      if (skid_valid) begin
        result <= skid;
      end else if (item_fire) begin
        result <= res;
      end
    end else if (item_fire) begin
      skid <= res;
    end
  end

endmodule

### hdl/lfsq_checker.sv
// ----------------------------------------------------------------------------
// lfsq_checker
// port-level checks on the largest free square dp unit
// ----------------------------------------------------------------------------
`include "largest_free_square_dp_unit_macros.svh"

module lfsq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_valid,
  input logic                        item_ready,
  input logic                        result_valid,
  input logic                        result_ready,
  input lfsq_pkg::lfsq_result_t      result
);
  import lfsq_pkg::*;

  // a stalled result stays offered and unchanged
  `LFSQ_ASSERT_NEXT(a_result_hold, clk, rst,
    result_valid && !result_ready, result_valid && $stable(result),
    "result changed while stalled")

  // a cell transfer with the output free is offered the next cycle
  `LFSQ_ASSERT_NEXT(a_transfer_gives_result, clk, rst,
    item_valid && item_ready && (!result_valid || result_ready), result_valid,
    "cell transfer without a result")

  // the running best never falls below the current side
  `LFSQ_ASSERT_NOW(a_best_covers_side, clk, rst,
    result_valid, result.best_side >= result.square_side,
    "best side below square side")

  // no best square yet means position zero
  `LFSQ_ASSERT_NOW(a_empty_best_pos, clk, rst,
    result_valid && (result.best_side == '0),
    (result.best_row == '0) && (result.best_column == '0),
    "best position set without a square")

endmodule

bind largest_free_square_dp_unit lfsq_checker u_lfsq_checker (.*);
